### design/dbnc_pkg.sv
package dbnc_pkg;

  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] THRESH_RESET = 8'd4;
  localparam int CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_POLL  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // per-button counter control, already qualified by the input transaction
  typedef struct packed {
    logic advance;  // poll with raw pattern equal to candidate
    logic clear;    // candidate replaced or clear command
  } lane_ctrl_t;

endpackage

### design/multi_button_debouncer_top.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | in_cmd, in_raw_buttons
// out     | output    | out_valid/out_stall | out_any_event, out_press_events,
//         |           |                   | out_irq_pending, out_debounced_state
// cfg     | input     | cfg_valid/cfg_ready | cfg_debounce_threshold
//
// One transaction per clock while in_stall is low: state updates at the accepting edge and the
// result appears in the output register on the next cycle.
// The rate is set by the one-deep output register: in_stall rises only while
// a held result is stalled by out_stall.
// rst_n is synchronous, active low; threshold resets to 4, all other state but the output data register to zero.
// cfg_ready is always high.
module multi_button_debouncer_top
  import dbnc_pkg::*;
#(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [NUM_BUTTONS-1:0] in_raw_buttons,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_any_event,
  output logic [NUM_BUTTONS-1:0] out_press_events,
  output logic                   out_irq_pending,
  output logic [NUM_BUTTONS-1:0] out_debounced_state,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_debounce_threshold
);

  localparam int RES_W = 2 * NUM_BUTTONS + 2;

  logic [CNT_W-1:0]       thresh_r;
  logic [NUM_BUTTONS-1:0] live_r, live_nxt;
  logic [NUM_BUTTONS-1:0] press_r, press_nxt;
  logic                   flag_r, flag_nxt;
  logic [NUM_BUTTONS-1:0] cand_r, cand_nxt;

  logic                   accept;
  logic                   busy;
  lane_ctrl_t             lane_ctrl;
  logic [NUM_BUTTONS-1:0] flips;
  logic                   event_c;
  logic [NUM_BUTTONS-1:0] presses_c;
  logic [RES_W-1:0]       res_c;
  logic [RES_W-1:0]       res_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_debounce_threshold;
    end
  end

  always_comb begin
    live_nxt          = live_r;
    press_nxt         = press_r;
    flag_nxt          = flag_r;
    cand_nxt          = cand_r;
    lane_ctrl.advance = 1'b0;
    lane_ctrl.clear   = 1'b0;
    event_c           = 1'b0;
    presses_c         = '0;
    if (accept) begin
      case (cmd_t'(in_cmd))
        CMD_POLL: begin
          if (in_raw_buttons != cand_r) begin
            cand_nxt        = in_raw_buttons;
            lane_ctrl.clear = 1'b1;
          end else begin
            lane_ctrl.advance = 1'b1;
            live_nxt  = live_r ^ flips;
            press_nxt = press_r | (flips & in_raw_buttons);
            flag_nxt  = flag_r | (|flips);
            event_c   = |flips;
          end
        end
        CMD_READ: begin
          presses_c = press_r;
          press_nxt = '0;
          flag_nxt  = 1'b0;
        end
        CMD_CLEAR: begin
          live_nxt        = '0;
          press_nxt       = '0;
          flag_nxt        = 1'b0;
          cand_nxt        = '0;
          lane_ctrl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r  <= '0;
      press_r <= '0;
      flag_r  <= 1'b0;
      cand_r  <= '0;
    end else begin
      live_r  <= live_nxt;
      press_r <= press_nxt;
      flag_r  <= flag_nxt;
      cand_r  <= cand_nxt;
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    dbnc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (lane_ctrl),
      .raw_bit   (in_raw_buttons[b]),
      .live_bit  (live_r[b]),
      .threshold (thresh_r),
      .flip      (flips[b])
    );
  end

  assign res_c = {event_c, presses_c, flag_nxt, live_nxt};

  dbnc_out_stage #(
    .W (RES_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (res_c),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_q)
  );

  assign out_any_event       = res_q[RES_W-1];
  assign out_press_events    = res_q[RES_W-2 -: NUM_BUTTONS];
  assign out_irq_pending     = res_q[NUM_BUTTONS];
  assign out_debounced_state = res_q[NUM_BUTTONS-1:0];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_READ) |=> (!flag_r && press_r == '0))
    else $error("read transaction did not clear events");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_CLEAR) |=> (live_r == '0 && cand_r == '0))
    else $error("clear transaction left state");

  a_event_sets_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_any_event) |-> out_irq_pending)
    else $error("event reported without pending interrupt");

endmodule

### design/dbnc_lane.sv
module dbnc_lane
  import dbnc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lane_ctrl_t       ctrl,
  input  logic             raw_bit,
  input  logic             live_bit,
  input  logic [CNT_W-1:0] threshold,
  output logic             flip
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  // saturating increment; a zero threshold flips on the first stable poll
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    flip    = 1'b0;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.advance) begin
      if (raw_bit != live_bit) begin
        if (cnt_inc >= threshold) begin
          flip    = 1'b1;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/dbnc_out_stage.sv
module dbnc_out_stage #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  logic [W-1:0] load_data,
  output logic         busy,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic         valid_nxt;
  logic [W-1:0] data_r;

  // holding a result that the sink refuses this cycle
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
